// ----- hdl/hufbp_pkg.sv -----
// Shared constants, codes and types for the Huffman table bit packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hufbp_pkg;

	localparam int NUM_SYMBOLS  = 256;
	localparam int MAX_CODE_LEN = 58;

	localparam int CODE_W    = MAX_CODE_LEN;
	localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
	localparam int SYM_W     = 8;
	localparam int SYM_IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int COUNT_W   = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'b00;
	localparam logic [1:0] REQ_ENCODE = 2'b01;
	localparam logic [1:0] REQ_FLUSH  = 2'b10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_PACK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic wr;     // write table entry
		logic rd;     // read table entry
		logic align;  // left-align fetched code
		logic pack;   // one packing step
		logic flush;  // emit final byte, clear stream state
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sym_ok;     // symbol indexes the table
		logic rem_zero;   // no code bits left
		logic full_byte;  // remaining bits fill the pending byte
		logic slot_free;  // output register can take a byte
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/hufbp_ctrl.sv -----
// Sequencer for the Huffman table bit packer.
// Depends on hufbp_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module hufbp_ctrl
	import hufbp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_type,
	output logic            req_stall,
	input  wire dp_sts_t    sts,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					unique case (req_type)
						REQ_LOAD: begin
							cmd.wr = sts.sym_ok;
						end
						REQ_ENCODE: begin
							if (sts.sym_ok) begin
								cmd.rd   = 1'b1;
								state_nx = ST_ALIGN;
							end
						end
						REQ_FLUSH: begin
							state_nx = ST_FLUSH;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ALIGN: begin
				cmd.align = 1'b1;
				state_nx  = ST_PACK;
			end
			ST_PACK: begin
				if (sts.rem_zero) begin
					state_nx = ST_IDLE;
				end else if (sts.full_byte) begin
					cmd.pack = sts.slot_free;
				end else begin
					// tail shorter than the open byte: absorb and finish
					cmd.pack = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (sts.slot_free) begin
					cmd.flush = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/hufbp_dp.sv -----
// Datapath: code table memory, bit accumulator, byte counter, output register.
// Depends on hufbp_pkg; controlled by hufbp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module hufbp_dp
	import hufbp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SYM_W-1:0]  symbol,
	input  wire logic [CODE_W-1:0] code_bits,
	input  wire logic [LEN_W-1:0]  code_len,
	input  wire ctrl_cmd_t         cmd,
	output dp_sts_t                sts,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [7:0]             out_byte,
	output logic                   last,
	output logic [COUNT_W-1:0]     byte_count
);

	entry_t table_mem [NUM_SYMBOLS];
	entry_t rd_q;

	logic [CODE_W-1:0]  code_q;   // remaining code bits, MSB aligned
	logic [LEN_W-1:0]   rem_q;
	logic [6:0]         acc_q;    // pending bits, right aligned
	logic [2:0]         cnt_q;
	logic [COUNT_W-1:0] full_q;

	logic               res_valid_q;
	logic [7:0]         out_byte_q;
	logic               last_q;
	logic [COUNT_W-1:0] byte_count_q;

	logic [SYM_IDX_W-1:0] idx;
	logic [LEN_W-1:0]     wr_len;
	logic [3:0]           need;
	logic [7:0]           top8;
	logic [2:0]           rem3;
	logic [7:0]           full_val;
	logic [7:0]           part_val;
	logic                 emit;
	logic [COUNT_W-1:0]   full_inc;

	assign idx    = SYM_IDX_W'(symbol);
	assign wr_len = (code_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_len;

	assign need     = 4'd8 - {1'b0, cnt_q};
	assign top8     = code_q[CODE_W-1 -: 8];
	assign rem3     = rem_q[2:0];
	assign full_val = 8'({1'b0, acc_q} << need) | (top8 >> cnt_q);
	assign part_val = 8'({1'b0, acc_q} << rem3) | (top8 >> (4'd8 - {1'b0, rem3}));
	assign full_inc = (full_q == COUNT_MAX) ? COUNT_MAX : full_q + COUNT_W'(1);

	assign sts.sym_ok    = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.full_byte = (rem_q >= LEN_W'(need));
	assign sts.slot_free = !res_valid_q || !res_stall;

	assign emit = (cmd.pack && sts.full_byte) || cmd.flush;

	// table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			table_mem[idx] <= '{len: wr_len, code: code_bits};
		end
		if (cmd.rd) begin
			rd_q <= table_mem[idx];
		end
	end

	// code shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.align) begin
			rem_q <= rd_q.len;
		end else if (cmd.pack) begin
			rem_q <= sts.full_byte ? rem_q - LEN_W'(need) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.align) begin
			code_q <= rd_q.code << (LEN_W'(CODE_W) - rd_q.len);
		end else if (cmd.pack && sts.full_byte) begin
			code_q <= code_q << need;
		end
	end

	// accumulator and stream byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			full_q <= '0;
		end else if (cmd.flush) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			full_q <= '0;
		end else if (cmd.pack) begin
			if (sts.full_byte) begin
				acc_q  <= '0;
				cnt_q  <= '0;
				full_q <= full_inc;
			end else begin
				acc_q <= part_val[6:0];
				cnt_q <= cnt_q + rem3;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.flush) begin
				out_byte_q   <= (cnt_q != '0) ? {1'b0, acc_q} : 8'd0;
				last_q       <= 1'b1;
				byte_count_q <= full_inc;
			end else begin
				out_byte_q   <= full_val;
				last_q       <= 1'b0;
				byte_count_q <= '0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;
	assign byte_count = byte_count_q;

endmodule

`default_nettype wire

// ----- hdl/huffman_table_bit_packer.sv -----
// Top level of the static Huffman encoder with loadable table and byte packer.
// Depends on hufbp_pkg, hufbp_ctrl and hufbp_dp.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  req     | in        | req_valid / req_stall  | req_type, symbol, code_bits, code_len
//  res     | out       | res_valid / res_stall  | out_byte, last, byte_count
//
// A load transfer leaves the sequencer idle, so the next request is taken right after.
// An encode transfer reads the table in its accepting cycle, then stalls the
// request side through one align step, one packing step per full byte and one
// closing step for a partial tail or no bits left.
// A flush waits until the output register is free, then emits the final byte.
// res_stall holds the output register and the packer waits behind it.
// arst_n clears the sequencer, accumulator, byte counter and output valid;
// the code table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_bit_packer
	import hufbp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [SYM_W-1:0]   symbol,
	input  wire logic [CODE_W-1:0]  code_bits,
	input  wire logic [LEN_W-1:0]   code_len,
	// result channel
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [7:0]              out_byte,
	output logic                    last,
	output logic [COUNT_W-1:0]      byte_count
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: accepts requests only while idle
	hufbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, bit accumulator and output register
	hufbp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.symbol     (symbol),
		.code_bits  (code_bits),
		.code_len   (code_len),
		.cmd        (cmd),
		.sts        (sts),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.last       (last),
		.byte_count (byte_count)
	);

endmodule

`default_nettype wire

// ----- hdl/hufbp_chk.sv -----
// Port-level checker for huffman_table_bit_packer, attached by bind.
// Depends on hufbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hufbp_chk
	import hufbp_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_stall,
	input wire logic [1:0]         req_type,
	input wire logic [SYM_W-1:0]   symbol,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic [7:0]         out_byte,
	input wire logic               last,
	input wire logic [COUNT_W-1:0] byte_count
);

	logic req_xfer;
	logic sym_in_range;

	assign req_xfer     = req_valid && !req_stall;
	assign sym_in_range = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte))
		else $error("result changed while stalled");

	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req_type == REQ_LOAD |=> !req_stall)
		else $error("load did not free the request side");

	a_encode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req_type == REQ_ENCODE && sym_in_range |=> req_stall)
		else $error("encode did not occupy the packer");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> byte_count == '0)
		else $error("byte count on a non-final byte");

	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |-> byte_count != '0)
		else $error("final byte with zero count");

endmodule

bind huffman_table_bit_packer hufbp_chk u_hufbp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.req_type   (req_type),
	.symbol     (symbol),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.out_byte   (out_byte),
	.last       (last),
	.byte_count (byte_count)
);

`default_nettype wire
